>>> rtl/rsi_pkg.sv
package rsi_pkg;

  localparam int AVG_W    = 40;
  localparam int PERIOD_W = 8;
  localparam int RSI_W    = 14;
  localparam int MULT_W   = 14;
  localparam int PROD_W   = AVG_W + MULT_W;
  localparam int DVS_W    = AVG_W + 1;

  localparam logic [AVG_W-1:0]    AVG_MAX      = {AVG_W{1'b1}};
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
  localparam logic [PERIOD_W-1:0] WARM_DONE    = 8'd255;
  localparam logic [RSI_W-1:0]    PCT_SQ       = 14'd10000;
  localparam logic [RSI_W-1:0]    FLAT_RSI     = 14'd5000;

  // operand source for the shared multiplier, divider and average write
  typedef enum logic [1:0] {
    SRC_GAIN = 2'd0,
    SRC_LOSS = 2'd1,
    SRC_RSI  = 2'd2
  } src_e;

  typedef struct packed {
    logic capture;
    logic check;
    logic mul_en;
    logic div_start;
    logic avg_wr;
    logic rsi_special;
    logic rsi_wr;
    logic out_load;
    src_e src;
  } cmd_t;

  typedef struct packed {
    logic warmup;
    logic warm_last;
    logic loss_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> rtl/rsi_div.sv
module rsi_div #(
  parameter int DVD_W = 54,
  parameter int DVS_W = 41
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DVS_W]) begin
        rem_d = diff[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/rsi_datapath.sv
module rsi_datapath #(
  parameter int RETURN_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsi_pkg::PERIOD_W-1:0]  cfg_wdata_i,
  input  logic [RETURN_BITS-1:0]        ret_i,
  input  rsi_pkg::cmd_t                 cmd_i,
  output rsi_pkg::status_t              st_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [rsi_pkg::RSI_W-1:0]     out_rsi_o,
  output logic                          out_rsi_valid_o,
  output logic                          out_flat_o
);

  localparam int AVG_W    = rsi_pkg::AVG_W;
  localparam int PERIOD_W = rsi_pkg::PERIOD_W;
  localparam int RSI_W    = rsi_pkg::RSI_W;
  localparam int MULT_W   = rsi_pkg::MULT_W;
  localparam int PROD_W   = rsi_pkg::PROD_W;
  localparam int DVS_W    = rsi_pkg::DVS_W;
  localparam int ACC_W    = ((AVG_W + PERIOD_W > RETURN_BITS) ? AVG_W + PERIOD_W
                                                              : RETURN_BITS) + 1;
  localparam int DVD_W    = (ACC_W > PROD_W) ? ACC_W : PROD_W;
  localparam int SUM_W    = ((AVG_W > RETURN_BITS) ? AVG_W : RETURN_BITS) + 1;

  logic [PERIOD_W-1:0]    period_q;
  logic [PERIOD_W-1:0]    count_q;
  logic [AVG_W-1:0]       gain_avg_q, loss_avg_q;
  logic [RETURN_BITS-1:0] gain_q, loss_q;
  logic                   warm_end_q;
  logic [PROD_W-1:0]      prod_q;
  logic [RSI_W-1:0]       res_rsi_q;
  logic                   res_valid_q, res_flat_q;
  logic                   out_valid_q;
  logic [RSI_W-1:0]       out_rsi_q;
  logic                   out_rsi_valid_q, out_flat_q;

  logic [PERIOD_W-1:0]    n;
  logic                   warmup;
  logic                   warm_last;
  logic [SUM_W-1:0]       gain_sum, loss_sum;
  logic [AVG_W-1:0]       gain_sum_sat, loss_sum_sat;
  logic [AVG_W-1:0]       mul_a;
  logic [MULT_W-1:0]      mul_b;
  logic [PROD_W-1:0]      prod_d;
  logic [RETURN_BITS-1:0] addend;
  logic [DVD_W-1:0]       div_dvd;
  logic [DVS_W-1:0]       div_dvs;
  logic                   div_done;
  logic [DVD_W-1:0]       div_quo;
  logic [AVG_W-1:0]       quo_sat;
  logic                   gain_zero;

  // a period of zero behaves as one
  assign n         = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign warmup    = count_q < n;
  assign warm_last = ({1'b0, count_q} + (PERIOD_W + 1)'(1)) >= {1'b0, n};

  assign gain_sum     = SUM_W'(gain_avg_q) + SUM_W'(gain_q);
  assign loss_sum     = SUM_W'(loss_avg_q) + SUM_W'(loss_q);
  assign gain_sum_sat = (gain_sum[SUM_W-1:AVG_W] != '0) ? rsi_pkg::AVG_MAX
                                                         : gain_sum[AVG_W-1:0];
  assign loss_sum_sat = (loss_sum[SUM_W-1:AVG_W] != '0) ? rsi_pkg::AVG_MAX
                                                         : loss_sum[AVG_W-1:0];

  // shared multiplier: avg*(N-1) for smoothing, avg*1 at end of warm-up, 10000*G
  always_comb begin
    mul_a = (cmd_i.src == rsi_pkg::SRC_LOSS) ? loss_avg_q : gain_avg_q;
    if (cmd_i.src == rsi_pkg::SRC_RSI) begin
      mul_b = rsi_pkg::PCT_SQ;
    end else if (warm_end_q) begin
      mul_b = MULT_W'(1);
    end else begin
      mul_b = MULT_W'(n - PERIOD_W'(1));
    end
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    if (warm_end_q) begin
      addend = '0;
    end else if (cmd_i.src == rsi_pkg::SRC_LOSS) begin
      addend = loss_q;
    end else begin
      addend = gain_q;
    end
    if (cmd_i.src == rsi_pkg::SRC_RSI) begin
      div_dvd = DVD_W'(prod_q);
      div_dvs = DVS_W'(gain_avg_q) + DVS_W'(loss_avg_q);
    end else begin
      div_dvd = DVD_W'(prod_q) + DVD_W'(addend);
      div_dvs = DVS_W'(n);
    end
  end

  rsi_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign quo_sat   = (div_quo[DVD_W-1:AVG_W] != '0) ? rsi_pkg::AVG_MAX
                                                   : div_quo[AVG_W-1:0];
  assign gain_zero = gain_avg_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= rsi_pkg::PERIOD_RESET;
      count_q     <= '0;
      gain_avg_q  <= '0;
      loss_avg_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (cmd_i.check && warmup) begin
        gain_avg_q <= gain_sum_sat;
        loss_avg_q <= loss_sum_sat;
        count_q    <= warm_last ? rsi_pkg::WARM_DONE : count_q + PERIOD_W'(1);
      end else if (cmd_i.avg_wr) begin
        if (cmd_i.src == rsi_pkg::SRC_LOSS) begin
          loss_avg_q <= quo_sat;
        end else begin
          gain_avg_q <= quo_sat;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      if (ret_i[RETURN_BITS-1]) begin
        gain_q <= '0;
        loss_q <= -ret_i;
      end else begin
        gain_q <= ret_i;
        loss_q <= '0;
      end
    end
    if (cmd_i.check) begin
      warm_end_q  <= warmup;
      res_rsi_q   <= '0;
      res_valid_q <= 1'b0;
      res_flat_q  <= 1'b0;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.rsi_special) begin
      res_valid_q <= 1'b1;
      res_flat_q  <= gain_zero;
      res_rsi_q   <= gain_zero ? rsi_pkg::FLAT_RSI : rsi_pkg::PCT_SQ;
    end else if (cmd_i.rsi_wr) begin
      res_valid_q <= 1'b1;
      res_flat_q  <= 1'b0;
      res_rsi_q   <= div_quo[RSI_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_rsi_q       <= res_rsi_q;
      out_rsi_valid_q <= res_valid_q;
      out_flat_q      <= res_flat_q;
    end
  end

  assign st_o.warmup    = warmup;
  assign st_o.warm_last = warm_last;
  assign st_o.loss_zero = loss_avg_q == '0;
  assign st_o.div_done  = div_done;
  assign st_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_rsi_o       = out_rsi_q;
  assign out_rsi_valid_o = out_rsi_valid_q;
  assign out_flat_o      = out_flat_q;

endmodule

>>> rtl/rsi_ctrl.sv
module rsi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rsi_pkg::status_t st_i,
  output rsi_pkg::cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_CHECK  = 12'b0000_0000_0010,
    ST_G_MUL  = 12'b0000_0000_0100,
    ST_G_DIV  = 12'b0000_0000_1000,
    ST_G_WAIT = 12'b0000_0001_0000,
    ST_L_MUL  = 12'b0000_0010_0000,
    ST_L_DIV  = 12'b0000_0100_0000,
    ST_L_WAIT = 12'b0000_1000_0000,
    ST_R_MUL  = 12'b0001_0000_0000,
    ST_R_DIV  = 12'b0010_0000_0000,
    ST_R_WAIT = 12'b0100_0000_0000,
    ST_OUT    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.src  = rsi_pkg::SRC_GAIN;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        // warm-up items short of the last one produce an empty result
        if (st_i.warmup && !st_i.warm_last) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_G_MUL;
        end
      end
      ST_G_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_G_DIV;
      end
      ST_G_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_G_WAIT;
      end
      ST_G_WAIT: begin
        if (st_i.div_done) begin
          cmd_o.avg_wr = 1'b1;
          state_d      = ST_L_MUL;
        end
      end
      ST_L_MUL: begin
        cmd_o.src    = rsi_pkg::SRC_LOSS;
        cmd_o.mul_en = 1'b1;
        state_d      = ST_L_DIV;
      end
      ST_L_DIV: begin
        cmd_o.src       = rsi_pkg::SRC_LOSS;
        cmd_o.div_start = 1'b1;
        state_d         = ST_L_WAIT;
      end
      ST_L_WAIT: begin
        cmd_o.src = rsi_pkg::SRC_LOSS;
        if (st_i.div_done) begin
          cmd_o.avg_wr = 1'b1;
          state_d      = ST_R_MUL;
        end
      end
      ST_R_MUL: begin
        cmd_o.src    = rsi_pkg::SRC_RSI;
        cmd_o.mul_en = 1'b1;
        if (st_i.loss_zero) begin
          cmd_o.rsi_special = 1'b1;
          state_d           = ST_OUT;
        end else begin
          state_d = ST_R_DIV;
        end
      end
      ST_R_DIV: begin
        cmd_o.src       = rsi_pkg::SRC_RSI;
        cmd_o.div_start = 1'b1;
        state_d         = ST_R_WAIT;
      end
      ST_R_WAIT: begin
        cmd_o.src = rsi_pkg::SRC_RSI;
        if (st_i.div_done) begin
          cmd_o.rsi_wr = 1'b1;
          state_d      = ST_OUT;
        end
      end
      ST_OUT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/relative_strength_index_top.sv
// Wilder RSI over a stream of signed Q8.24 returns: each accepted sample gives
// one result, the RSI in hundredths (tdata) with a valid flag that stays low
// for the first N-1 samples and a flat-market flag (tuser). Items are handled
// one at a time. A warm-up sample that does not end warm-up goes from the check
// state straight to the output state. Every other sample runs the shared
// one-bit-per-cycle divider over a 54-bit dividend for the gain average, the
// loss average and then 10000*G/(G+L), the last division skipped when the loss
// average is zero. A sample also holds the block while the previous result
// still waits in the output register. The next sample is taken while a result
// waits there. smoothing_period (reset 14, 0 acts as 1) is written through
// cfg_we_i/cfg_wdata_i and must only change while idle.
module relative_strength_index_top #(
  parameter int RETURN_BITS = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [rsi_pkg::PERIOD_W-1:0]             cfg_wdata_i,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [RETURN_BITS-1:0] return_value, rest zero
  input  logic [((RETURN_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // [13:0] rsi_hundredths, [15:14] zero
  output logic [((rsi_pkg::RSI_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // [0] rsi_valid, [1] flat_market
  output logic [1:0]                               m_axis_tuser
);

  localparam int OUT_W = ((rsi_pkg::RSI_W + 7) / 8) * 8;

  rsi_pkg::cmd_t           cmd;
  rsi_pkg::status_t        st;
  logic [rsi_pkg::RSI_W-1:0] out_rsi;
  logic                    out_rsi_valid;
  logic                    out_flat;

  rsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  rsi_datapath #(
    .RETURN_BITS (RETURN_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .ret_i           (s_axis_tdata[RETURN_BITS-1:0]),
    .cmd_i           (cmd),
    .st_o            (st),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_rsi_o       (out_rsi),
    .out_rsi_valid_o (out_rsi_valid),
    .out_flat_o      (out_flat)
  );

  assign m_axis_tdata = OUT_W'(out_rsi);
  assign m_axis_tuser = {out_flat, out_rsi_valid};

  a_rsi_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_rsi <= rsi_pkg::PCT_SQ)
    else $error("rsi above 100.00");

  a_flat_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_flat |-> out_rsi_valid && out_rsi == rsi_pkg::FLAT_RSI)
    else $error("flat market result is not a valid 50.00");

  a_warmup_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_rsi_valid |-> out_rsi == '0 && !out_flat)
    else $error("warm-up result carries data");

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while one is in progress");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int RET_W     = 32;
  localparam int SEG_ITEMS = 122;

  typedef enum int {
    TREND_MIXED,
    TREND_RISE,
    TREND_FALL,
    TREND_QUIET
  } trend_e;

  typedef struct packed {
    logic [rsi_pkg::RSI_W-1:0] rsi;
    logic                      valid;
    logic                      flat;
  } rsi_result_t;

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [rsi_pkg::PERIOD_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [RET_W-1:0] s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  // predictor state
  logic [rsi_pkg::PERIOD_W-1:0] period_q = rsi_pkg::PERIOD_RESET;
  logic [rsi_pkg::AVG_W-1:0]    gain_avg = '0;
  logic [rsi_pkg::AVG_W-1:0]    loss_avg = '0;
  logic [rsi_pkg::PERIOD_W-1:0] warm_cnt = '0;

  logic [RET_W-1:0] return_q[$];
  rsi_result_t      rsi_expect_q[$];
  int               sender_idle_pct = 0;
  int               recv_idle_pct   = 0;
  int               err_cnt         = 0;

  relative_strength_index_top #(
    .RETURN_BITS(RET_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [rsi_pkg::AVG_W-1:0] clip_avg(input logic [63:0] v);
    return (v > 64'(rsi_pkg::AVG_MAX)) ? rsi_pkg::AVG_MAX : v[rsi_pkg::AVG_W-1:0];
  endfunction

  // one sample through warm-up / Wilder smoothing, returns the expected result
  function automatic rsi_result_t wilder_rsi_step(input logic [RET_W-1:0] ret);
    logic [63:0]      gain;
    logic [63:0]      loss;
    logic [63:0]      n;
    logic [63:0]      total;
    logic [RET_W-1:0] mag;
    rsi_result_t      res;
    gain = '0;
    loss = '0;
    res  = '0;
    n    = (period_q == '0) ? 64'd1 : 64'(period_q);
    mag  = -ret;
    if (ret[RET_W-1]) begin
      loss = 64'(mag);
    end else begin
      gain = 64'(ret);
    end
    if (64'(warm_cnt) < n) begin
      gain_avg = clip_avg(64'(gain_avg) + gain);
      loss_avg = clip_avg(64'(loss_avg) + loss);
      warm_cnt = warm_cnt + 1'b1;
      if (64'(warm_cnt) >= n) begin
        gain_avg  = rsi_pkg::AVG_W'(64'(gain_avg) / n);
        loss_avg  = rsi_pkg::AVG_W'(64'(loss_avg) / n);
        warm_cnt  = rsi_pkg::WARM_DONE;
        res.valid = 1'b1;
      end
    end else begin
      gain_avg  = clip_avg((64'(gain_avg) * (n - 1) + gain) / n);
      loss_avg  = clip_avg((64'(loss_avg) * (n - 1) + loss) / n);
      res.valid = 1'b1;
    end
    if (res.valid) begin
      if (gain_avg == '0 && loss_avg == '0) begin
        res.rsi  = rsi_pkg::FLAT_RSI;
        res.flat = 1'b1;
      end else if (loss_avg == '0) begin
        res.rsi = rsi_pkg::PCT_SQ;
      end else begin
        total   = 64'(gain_avg) + 64'(loss_avg);
        res.rsi = rsi_pkg::RSI_W'(64'(rsi_pkg::PCT_SQ) * 64'(gain_avg) / total);
      end
    end
    return res;
  endfunction

  // returns shaped as market moves: choppy, rallies, sell-offs, flat stretches
  function automatic logic [RET_W-1:0] draw_return(input trend_e tr);
    logic [RET_W-1:0] mag;
    mag = $urandom >> $urandom_range(1, 31);
    case (tr)
      TREND_RISE:  return mag;
      TREND_FALL:  return ($urandom_range(0, 15) == 0) ? 32'h8000_0000 : -mag;
      TREND_QUIET: return ($urandom_range(0, 31) == 0) ? 32'h0000_0001 : '0;
      default: begin
        case ($urandom_range(0, 7))
          0:       return $urandom;
          1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          2:       return '0;
          default: return $urandom_range(0, 1) ? mag : -mag;
        endcase
      end
    endcase
  endfunction

  task automatic queue_return(input logic [RET_W-1:0] r);
    return_q = {return_q, r};
  endtask

  task automatic drain();
    while (return_q.size() != 0 || s_axis_tvalid || rsi_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_period(input logic [rsi_pkg::PERIOD_W-1:0] p);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= p;
    period_q     = p;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rsi_expect_q = {rsi_expect_q, wilder_rsi_step(s_axis_tdata)};
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (return_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= return_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    rsi_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rsi_expect_q.size() == 0) begin
          $display("%0t: unexpected result, rsi_hundredths %0d", $time,
                   m_axis_tdata[rsi_pkg::RSI_W-1:0]);
          err_cnt++;
        end else begin
          want = rsi_expect_q.pop_front();
          if (m_axis_tdata[rsi_pkg::RSI_W-1:0] !== want.rsi) begin
            $display("%0t: rsi_hundredths expected %0d, got %0d", $time, want.rsi,
                     m_axis_tdata[rsi_pkg::RSI_W-1:0]);
            err_cnt++;
          end
          if (m_axis_tuser[0] !== want.valid) begin
            $display("%0t: rsi_valid expected %0b, got %0b", $time, want.valid,
                     m_axis_tuser[0]);
            err_cnt++;
          end
          if (m_axis_tuser[1] !== want.flat) begin
            $display("%0t: flat_market expected %0b, got %0b", $time, want.flat,
                     m_axis_tuser[1]);
            err_cnt++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int                           seg;
    int                           n;
    int                           burst;
    trend_e                       tr;
    logic [rsi_pkg::PERIOD_W-1:0] p;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    sender_idle_pct = 28;
    recv_idle_pct   = 68;

    // warm-up starts at the reset period, which then drops to 3 mid warm-up
    queue_return(32'hFFFF_FFFF);
    queue_return(32'h7FFF_FFFF);
    drain();
    write_period(8'd3);
    queue_return(32'h8000_0000);
    queue_return(32'h0000_0001);
    queue_return(32'h0000_0000);
    queue_return(32'h0100_0000);
    drain();
    // zero period acts as 1: averages follow the sample directly
    write_period(8'd0);
    queue_return(32'h0000_0000);
    queue_return(32'h0000_0005);
    queue_return(32'hFFFF_FFFB);
    queue_return(32'h8000_0000);
    queue_return(32'h7FFF_FFFF);
    queue_return(32'h0000_0000);
    drain();
    write_period(8'd255);
    queue_return(32'h8000_0000);
    queue_return(32'h7FFF_FFFF);
    queue_return(32'h0000_0001);
    queue_return(32'hFFFF_FFFF);
    drain();

    for (seg = 0; seg < 8; seg++) begin
      if (seg == 3) begin
        sender_idle_pct = 68;
        recv_idle_pct   = 28;
      end else if (seg == 6) begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      case (seg)
        0:       p = 8'd255;
        1:       p = 8'd1;
        2:       p = 8'd0;
        3:       p = 8'd14;
        4:       p = 8'd2;
        5:       p = rsi_pkg::PERIOD_W'($urandom_range(3, 254));
        6:       p = 8'd254;
        default: p = rsi_pkg::PERIOD_W'($urandom_range(1, 255));
      endcase
      write_period(p);
      n = 0;
      while (n < SEG_ITEMS) begin
        tr    = ($urandom_range(0, 1) == 0) ? TREND_MIXED : trend_e'($urandom_range(1, 3));
        burst = $urandom_range(3, 40);
        repeat (burst) begin
          queue_return(draw_return(tr));
          n++;
        end
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/rsi_pkg.sv
rtl/rsi_div.sv
rtl/rsi_datapath.sv
rtl/rsi_ctrl.sv
rtl/relative_strength_index_top.sv
dv/testbench.sv
